// ===== hdl/ttfd_pkg.sv =====
`default_nettype none
package ttfd_pkg;

    localparam int MaxDim = 1024;
    localparam int PalDepth = 256;
    localparam int Lanes = 16;

    localparam logic [3:0] FMT_I4     = 4'd0;
    localparam logic [3:0] FMT_I8     = 4'd1;
    localparam logic [3:0] FMT_IA4    = 4'd2;
    localparam logic [3:0] FMT_IA8    = 4'd3;
    localparam logic [3:0] FMT_RGB565 = 4'd4;
    localparam logic [3:0] FMT_RGB5A3 = 4'd5;
    localparam logic [3:0] FMT_RGBA8  = 4'd6;
    localparam logic [3:0] FMT_CMPR   = 4'd7;
    localparam logic [3:0] FMT_CI4    = 4'd8;
    localparam logic [3:0] FMT_CI8    = 4'd9;

    localparam logic [1:0] PK_IA8    = 2'd0;
    localparam logic [1:0] PK_RGB565 = 2'd1;
    localparam logic [1:0] PK_RGB5A3 = 2'd2;
    localparam logic [1:0] PK_BLACK  = 2'd3;

    localparam logic [1:0] REG_TEXEL_FORMAT   = 2'd0;
    localparam logic [1:0] REG_PALETTE_FORMAT = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd2;
    localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd3;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_rgba;

    typedef struct packed {
        logic       en;
        logic [9:0] x;
        logic [9:0] y;
        logic       is_pal;
        logic [7:0] pidx;
        t_rgba      c;
    } t_lane;

    typedef struct packed {
        logic idle;
        logic can_load;
    } t_mstat;

    function automatic logic [7:0] ex5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] ex6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [7:0] ex4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] v);
        logic [20:0] p;
        p = 21'(v) * 21'd683;
        return p[18:11];
    endfunction

    function automatic t_rgba color16(input logic [15:0] v, input logic [1:0] kind);
        t_rgba c;
        unique case (kind)
            PK_IA8: c = '{r: v[7:0], g: v[7:0], b: v[7:0], a: v[15:8]};
            PK_RGB565: c = '{r: ex5(v[15:11]), g: ex6(v[10:5]), b: ex5(v[4:0]), a: 8'hFF};
            PK_RGB5A3: begin
                if (v[15]) begin
                    c = '{r: ex5(v[14:10]), g: ex5(v[9:5]), b: ex5(v[4:0]), a: 8'hFF};
                end else begin
                    c = '{r: ex4(v[11:8]), g: ex4(v[7:4]), b: ex4(v[3:0]),
                          a: {v[14:12], v[14:12], v[14:13]}};
                end
            end
            default: c = '{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'hFF};
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ttfd_if.sv =====
`default_nettype none
interface ttfd_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [63:0] data_word;
    logic [7:0]  pal_index;
    logic [15:0] pal_value;
    modport source(output valid, op, data_word, pal_index, pal_value, input ready);
    modport sink(input valid, op, data_word, pal_index, pal_value, output ready);
endinterface

interface ttfd_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] pos_x;
    logic [9:0] pos_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
    modport source(output valid, pos_x, pos_y, red, green, blue, alpha, last, input ready);
    modport sink(input valid, pos_x, pos_y, red, green, blue, alpha, last, output ready);
endinterface

interface ttfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/ttfd_lane.sv =====
`default_nettype none
module ttfd_lane (
    input  wire logic [3:0]             i_lane,
    input  wire logic [3:0]             i_fmt,
    input  wire logic [2:0]             i_sub,
    input  wire logic [63:0]            i_word,
    input  wire logic [63:0]            i_ar,
    input  wire ttfd_pkg::t_rgba [3:0]  i_cmp,
    input  wire logic [12:0]            i_bx,
    input  wire logic [12:0]            i_by,
    input  wire logic [10:0]            i_ew,
    input  wire logic [10:0]            i_eh,
    output ttfd_pkg::t_lane             o_lane
);

    always_comb begin
        logic [7:0]  by [8];
        logic [7:0]  ab [8];
        logic [7:0]  b;
        logic [3:0]  v;
        logic [1:0]  ci;
        logic [3:0]  dx;
        logic [3:0]  dy;
        logic        en;
        logic [12:0] px;
        logic [12:0] py;
        ttfd_pkg::t_rgba c;
        logic        is_pal;
        logic [7:0]  pidx;
        for (int j = 0; j < 8; j++) begin
            by[j] = i_word[63 - 8 * j -: 8];
            ab[j] = i_ar[63 - 8 * j -: 8];
        end
        b = '0;
        v = '0;
        ci = '0;
        dx = '0;
        dy = '0;
        en = 1'b0;
        c = '0;
        is_pal = 1'b0;
        pidx = '0;
        unique case (i_fmt)
            ttfd_pkg::FMT_I4, ttfd_pkg::FMT_CI4: begin
                b = by[i_lane[3:1]];
                v = i_lane[0] ? b[3:0] : b[7:4];
                dx = {1'b0, i_lane[2:0]};
                dy = {1'b0, i_sub[1:0], i_lane[3]};
                en = 1'b1;
                c = '{r: ttfd_pkg::ex4(v), g: ttfd_pkg::ex4(v), b: ttfd_pkg::ex4(v),
                      a: 8'hFF};
                is_pal = (i_fmt == ttfd_pkg::FMT_CI4);
                pidx = {4'b0, v};
            end
            ttfd_pkg::FMT_I8, ttfd_pkg::FMT_IA4, ttfd_pkg::FMT_CI8: begin
                b = by[i_lane[2:0]];
                dx = {1'b0, i_lane[2:0]};
                dy = {2'b0, i_sub[1:0]};
                en = !i_lane[3];
                if (i_fmt == ttfd_pkg::FMT_I8) begin
                    c = '{r: b, g: b, b: b, a: 8'hFF};
                end else begin
                    c = '{r: ttfd_pkg::ex4(b[3:0]), g: ttfd_pkg::ex4(b[3:0]),
                          b: ttfd_pkg::ex4(b[3:0]), a: ttfd_pkg::ex4(b[7:4])};
                end
                is_pal = (i_fmt == ttfd_pkg::FMT_CI8);
                pidx = b;
            end
            ttfd_pkg::FMT_IA8, ttfd_pkg::FMT_RGB565, ttfd_pkg::FMT_RGB5A3: begin
                dx = {2'b0, i_lane[1:0]};
                dy = {2'b0, i_sub[1:0]};
                en = (i_lane[3:2] == 2'b00);
                c = ttfd_pkg::color16({by[{i_lane[1:0], 1'b0}], by[{i_lane[1:0], 1'b1}]},
                        (i_fmt == ttfd_pkg::FMT_IA8) ? ttfd_pkg::PK_IA8 :
                        (i_fmt == ttfd_pkg::FMT_RGB565) ? ttfd_pkg::PK_RGB565 :
                        ttfd_pkg::PK_RGB5A3);
            end
            ttfd_pkg::FMT_RGBA8: begin
                dx = {2'b0, i_lane[1:0]};
                dy = {2'b0, i_sub[1:0]};
                en = i_sub[2] && (i_lane[3:2] == 2'b00);
                c = '{r: ab[{i_lane[1:0], 1'b1}], g: by[{i_lane[1:0], 1'b0}],
                      b: by[{i_lane[1:0], 1'b1}], a: ab[{i_lane[1:0], 1'b0}]};
            end
            ttfd_pkg::FMT_CMPR: begin
                b = by[{1'b1, i_lane[3:2]}];
                ci = 2'(b >> {~i_lane[1:0], 1'b0});
                dx = {1'b0, i_sub[0], i_lane[1:0]};
                dy = {1'b0, i_sub[1], i_lane[3:2]};
                en = 1'b1;
                c = i_cmp[ci];
            end
            default: en = 1'b0;
        endcase
        px = i_bx + 13'(dx);
        py = i_by + 13'(dy);
        o_lane.en = en && (px < 13'(i_ew)) && (py < 13'(i_eh));
        o_lane.x = px[9:0];
        o_lane.y = py[9:0];
        o_lane.is_pal = is_pal;
        o_lane.pidx = pidx;
        o_lane.c = c;
    end

endmodule
`default_nettype wire

// ===== hdl/ttfd_merge.sv =====
`default_nettype none
module ttfd_merge (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_load,
    input  wire ttfd_pkg::t_lane [ttfd_pkg::Lanes-1:0] i_lanes,
    input  wire logic                            i_pal_we,
    input  wire logic [7:0]                      i_pal_idx,
    input  wire logic [15:0]                     i_pal_val,
    input  wire logic [1:0]                      i_pfmt,
    output ttfd_pkg::t_mstat                     o_stat,
    ttfd_out_if.source                           o_out
);

    ttfd_pkg::t_lane [ttfd_pkg::Lanes-1:0] r_lanes;
    logic [ttfd_pkg::Lanes-1:0] r_mask;
    logic [15:0] r_pal [ttfd_pkg::PalDepth];
    logic [15:0] r_pal_q;
    logic        r_b_valid;
    ttfd_pkg::t_lane r_b;
    logic        r_b_last;
    logic        r_o_valid;
    logic [9:0]  r_o_x;
    logic [9:0]  r_o_y;
    ttfd_pkg::t_rgba r_o_c;
    logic        r_o_last;

    logic [ttfd_pkg::Lanes-1:0] pick;
    logic [ttfd_pkg::Lanes-1:0] rem;
    logic [3:0]  sel;
    logic        c_free;
    logic        b_free;
    logic        issue;
    logic        last;
    logic [ttfd_pkg::Lanes-1:0] n_mask;
    logic [ttfd_pkg::Lanes-1:0] load_mask;

    always_comb begin
        sel = '0;
        for (int k = ttfd_pkg::Lanes - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                sel = 4'(k);
            end
        end
        pick = '0;
        pick[sel] = |r_mask;
        rem = r_mask & ~pick;
        for (int k = 0; k < ttfd_pkg::Lanes; k++) begin
            load_mask[k] = i_lanes[k].en;
        end
    end

    assign c_free = !r_o_valid || o_out.ready;
    assign b_free = !r_b_valid || c_free;
    assign issue = (|r_mask) && b_free;
    assign last = (rem == '0);
    assign o_stat.idle = (r_mask == '0);
    assign o_stat.can_load = (r_mask == '0) || (issue && last);

    always_comb begin
        n_mask = r_mask;
        if (i_load) begin
            n_mask = load_mask;
        end else if (issue) begin
            n_mask = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (b_free) begin
                r_b_valid <= issue;
            end
            if (c_free) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lanes <= i_lanes;
        end
        if (i_pal_we) begin
            r_pal[i_pal_idx] <= i_pal_val;
        end
        if (issue) begin
            r_pal_q <= r_pal[r_lanes[sel].pidx];
            r_b <= r_lanes[sel];
            r_b_last <= last;
        end
        if (c_free && r_b_valid) begin
            r_o_x <= r_b.x;
            r_o_y <= r_b.y;
            r_o_c <= r_b.is_pal ? ttfd_pkg::color16(r_pal_q, i_pfmt) : r_b.c;
            r_o_last <= r_b_last;
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.pos_x = r_o_x;
    assign o_out.pos_y = r_o_y;
    assign o_out.red = r_o_c.r;
    assign o_out.green = r_o_c.g;
    assign o_out.blue = r_o_c.b;
    assign o_out.alpha = r_o_c.a;
    assign o_out.last = r_o_last;

endmodule
`default_nettype wire

// ===== hdl/tiled_texel_format_decoder.sv =====
// Tiled texel decoder: expands 64-bit tiled source words into RGBA8 texels.
// Input channel i_in carries image words (op 0) and palette writes (op 1).
// Output channel o_out carries one texel per beat with its image position;
// last marks the final texel that one source word produced.
// Configuration channel i_cfg is always ready; write it only while idle.
// Sixteen lanes decode every texel of a word in the cycle it is accepted,
// and a merge stage sends the visible ones out one per cycle unless the
// receiver stalls, through a single palette read port. Accepted texels are
// registered in the lane buffer, then pass a palette read register and an
// output register. A word that yields no texel sends nothing out.
// The next word is accepted in the cycle its predecessor's last texel
// enters the output pipeline. A palette write waits until every texel of
// earlier words has read the palette.
// A synchronous reset sets the configuration registers to their defaults and
// clears the tile position and all pending texels; palette contents are
// undefined until written. When the receiver stalls, the output and palette
// read stages hold, and input is refused once the texel buffer cannot drain.
`default_nettype none
module tiled_texel_format_decoder (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ttfd_in_if.sink     i_in,
    ttfd_out_if.source  o_out,
    ttfd_cfg_if.sink    i_cfg
);

    logic [3:0]  r_fmt;
    logic [1:0]  r_pfmt;
    logic [10:0] r_w;
    logic [10:0] r_h;
    logic [9:0]  r_col;
    logic [9:0]  r_row;
    logic [2:0]  r_wit;
    logic [63:0] r_ar [4];

    logic        supported;
    logic        tw8;
    logic        th8;
    logic        wd8;
    logic [2:0]  sub;
    logic [10:0] ew;
    logic [10:0] eh;
    logic [12:0] bx;
    logic [12:0] by;
    logic [12:0] nx;
    logic [12:0] ny;
    logic [15:0] c0;
    logic [15:0] c1;
    ttfd_pkg::t_rgba p0;
    ttfd_pkg::t_rgba p1;
    ttfd_pkg::t_rgba [3:0] cmp;
    ttfd_pkg::t_lane [ttfd_pkg::Lanes-1:0] lanes;
    ttfd_pkg::t_mstat mstat;
    logic        acc;
    logic        word_acc;
    logic        pal_acc;

    assign supported = (r_fmt <= ttfd_pkg::FMT_CI8);
    assign tw8 = (r_fmt == ttfd_pkg::FMT_I4) || (r_fmt == ttfd_pkg::FMT_I8) ||
                 (r_fmt == ttfd_pkg::FMT_IA4) || (r_fmt == ttfd_pkg::FMT_CMPR) ||
                 (r_fmt == ttfd_pkg::FMT_CI4) || (r_fmt == ttfd_pkg::FMT_CI8);
    assign th8 = (r_fmt == ttfd_pkg::FMT_I4) || (r_fmt == ttfd_pkg::FMT_CMPR) ||
                 (r_fmt == ttfd_pkg::FMT_CI4);
    assign wd8 = (r_fmt == ttfd_pkg::FMT_RGBA8);
    assign sub = wd8 ? r_wit : {1'b0, r_wit[1:0]};
    assign ew = (r_w > 11'(ttfd_pkg::MaxDim)) ? 11'(ttfd_pkg::MaxDim) : r_w;
    assign eh = (r_h > 11'(ttfd_pkg::MaxDim)) ? 11'(ttfd_pkg::MaxDim) : r_h;
    assign bx = tw8 ? {r_col, 3'b0} : {1'b0, r_col, 2'b0};
    assign by = th8 ? {r_row, 3'b0} : {1'b0, r_row, 2'b0};
    assign nx = bx + (tw8 ? 13'd8 : 13'd4);
    assign ny = by + (th8 ? 13'd8 : 13'd4);

    assign c0 = i_in.data_word[63:48];
    assign c1 = i_in.data_word[47:32];
    assign p0 = ttfd_pkg::color16(c0, ttfd_pkg::PK_RGB565);
    assign p1 = ttfd_pkg::color16(c1, ttfd_pkg::PK_RGB565);

    always_comb begin
        cmp[0] = p0;
        cmp[1] = p1;
        if (c0 > c1) begin
            cmp[2].r = ttfd_pkg::div3({1'b0, p0.r, 1'b0} + 10'(p1.r));
            cmp[2].g = ttfd_pkg::div3({1'b0, p0.g, 1'b0} + 10'(p1.g));
            cmp[2].b = ttfd_pkg::div3({1'b0, p0.b, 1'b0} + 10'(p1.b));
            cmp[3].r = ttfd_pkg::div3(10'(p0.r) + {1'b0, p1.r, 1'b0});
            cmp[3].g = ttfd_pkg::div3(10'(p0.g) + {1'b0, p1.g, 1'b0});
            cmp[3].b = ttfd_pkg::div3(10'(p0.b) + {1'b0, p1.b, 1'b0});
            cmp[3].a = 8'hFF;
        end else begin
            cmp[2].r = 8'((9'(p0.r) + 9'(p1.r)) >> 1);
            cmp[2].g = 8'((9'(p0.g) + 9'(p1.g)) >> 1);
            cmp[2].b = 8'((9'(p0.b) + 9'(p1.b)) >> 1);
            cmp[3] = '0;
        end
        cmp[2].a = 8'hFF;
    end

    for (genvar k = 0; k < ttfd_pkg::Lanes; k++) begin : g_lane
        ttfd_lane u_lane (
            .i_lane (4'(k)),
            .i_fmt  (r_fmt),
            .i_sub  (sub),
            .i_word (i_in.data_word),
            .i_ar   (r_ar[sub[1:0]]),
            .i_cmp  (cmp),
            .i_bx   (bx),
            .i_by   (by),
            .i_ew   (ew),
            .i_eh   (eh),
            .o_lane (lanes[k])
        );
    end

    assign i_in.ready = i_in.op ? mstat.idle : mstat.can_load;
    assign acc = i_in.valid && i_in.ready;
    assign word_acc = acc && !i_in.op;
    assign pal_acc = acc && i_in.op;
    assign i_cfg.ready = 1'b1;

    ttfd_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (word_acc),
        .i_lanes   (lanes),
        .i_pal_we  (pal_acc),
        .i_pal_idx (i_in.pal_index),
        .i_pal_val (i_in.pal_value),
        .i_pfmt    (r_pfmt),
        .o_stat    (mstat),
        .o_out     (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= ttfd_pkg::FMT_I4;
            r_pfmt <= ttfd_pkg::PK_IA8;
            r_w <= 11'd1;
            r_h <= 11'd1;
            r_col <= '0;
            r_row <= '0;
            r_wit <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    ttfd_pkg::REG_TEXEL_FORMAT:   r_fmt <= i_cfg.data[3:0];
                    ttfd_pkg::REG_PALETTE_FORMAT: r_pfmt <= i_cfg.data[1:0];
                    ttfd_pkg::REG_IMAGE_WIDTH:    r_w <= i_cfg.data;
                    ttfd_pkg::REG_IMAGE_HEIGHT:   r_h <= i_cfg.data;
                    default: ;
                endcase
            end
            if (word_acc && supported) begin
                if (r_wit >= (wd8 ? 3'd7 : 3'd3)) begin
                    r_wit <= '0;
                    if (nx >= 13'(ew)) begin
                        r_col <= '0;
                        r_row <= (ny >= 13'(eh)) ? 10'd0 : r_row + 10'd1;
                    end else begin
                        r_col <= r_col + 10'd1;
                    end
                end else begin
                    r_wit <= r_wit + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (word_acc && wd8 && !sub[2]) begin
            r_ar[sub[1:0]] <= i_in.data_word;
        end
    end

endmodule
`default_nettype wire
